FILE: sv/rtam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rtam_pkg;

  localparam int KEY_BITS       = 32;
  localparam int VALUE_BITS     = 32;
  localparam int DEF_CHUNK_LOG2 = 4;
  localparam int DEF_MAX_PAGES  = 256;

  localparam logic [VALUE_BITS-1:0] UNASSIGNED = '1;

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_ASSIGN = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [KEY_BITS-1:0]   logical_key;
    logic [VALUE_BITS-1:0] physical_value;
  } req_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] result_value;
    logic                  found;
    logic                  out_of_space;
  } rsp_t;

  typedef struct packed {
    logic idle;
    logic done;
  } walk_stat_t;

endpackage

`default_nettype wire

FILE: sv/rtam_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module rtam_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [WIDTH-1:0]  wdata,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/rtam_walker.sv
`timescale 1ns / 1ps
`default_nettype none

module rtam_walker
  import rtam_pkg::*;
#(
  parameter int CHUNK_LOG2 = DEF_CHUNK_LOG2,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire req_t       req,
  input  wire logic       take,
  output walk_stat_t      stat,
  output rsp_t            rsp
);

  localparam int STRIDE    = CHUNK_LOG2 - 1;
  localparam int CHUNK     = 1 << CHUNK_LOG2;
  localparam int MAX_LEVEL = (KEY_BITS - 1) / STRIDE;
  localparam int LVL_W     = $clog2(MAX_LEVEL + 1);
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int NF_W      = $clog2(MAX_PAGES + 1);
  localparam int ADDR_W    = PAGE_W + CHUNK_LOG2;
  localparam int SH_W      = $clog2(KEY_BITS);
  localparam int SUM_W     = ((NF_W > LVL_W) ? NF_W : LVL_W) + 2;

  typedef enum logic [3:0] {
    IDLE, NEWCHK, WALK_RD, WALK_EV, CHECK, STACK, STACK_NX,
    EXEC_RD, EXEC_EV, FILL, DONE
  } state_t;

  state_t                  state, ret;
  mode_t                   mode_r;
  logic [KEY_BITS-1:0]     key_r;
  logic [VALUE_BITS-1:0]   val_r;
  logic [LVL_W-1:0]        req_r, lvl, extra, root_lvl;
  logic [PAGE_W-1:0]       page, prev, root, fill_page;
  logic [CHUNK_LOG2-1:0]   fill_cnt;
  logic [VALUE_BITS-1:0]   fill_first;
  logic [NF_W-1:0]         next_free;

  logic [LVL_W-1:0]        req_lvl, need;
  logic [SH_W-1:0]         shamt;
  logic [KEY_BITS-1:0]     key_sh;
  logic [CHUNK_LOG2-1:0]   slot;
  logic [VALUE_BITS-1:0]   nf_ext, rdata, wdata;
  logic                    ptr_ok, we;
  logic [ADDR_W-1:0]       addr;
  logic [SUM_W-1:0]        pool_need;

  // level a key needs: highest h with key >> (STRIDE*h) nonzero
  always_comb begin
    req_lvl = '0;
    for (int i = 1; i <= MAX_LEVEL; i++) begin
      if ((req.logical_key >> (STRIDE * i)) != '0) begin
        req_lvl = LVL_W'(i);
      end
    end
  end

  assign shamt     = SH_W'(lvl) * SH_W'(STRIDE);
  assign key_sh    = key_r >> shamt;
  assign slot      = key_sh[CHUNK_LOG2-1:0];
  assign nf_ext    = VALUE_BITS'(next_free);
  assign ptr_ok    = (rdata != UNASSIGNED) && (rdata < nf_ext);
  assign need      = (req_r > root_lvl) ? (req_r - root_lvl) : '0;
  assign pool_need = SUM_W'(next_free) + SUM_W'(need) + SUM_W'(extra);

  always_comb begin
    we    = 1'b0;
    addr  = {page, slot};
    wdata = UNASSIGNED;
    unique case (state)
      FILL: begin
        we    = 1'b1;
        addr  = {fill_page, fill_cnt};
        wdata = (fill_cnt == '0) ? fill_first : UNASSIGNED;
      end
      EXEC_RD: begin
        we    = (lvl == '0);
        wdata = val_r;
      end
      EXEC_EV: begin
        we    = !ptr_ok;
        wdata = nf_ext;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  rtam_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_PAGES * CHUNK)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign stat.idle = (state == IDLE);
  assign stat.done = (state == DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= FILL;
      ret        <= IDLE;
      fill_page  <= '0;
      fill_cnt   <= '0;
      fill_first <= UNASSIGNED;
      root       <= '0;
      root_lvl   <= '0;
      next_free  <= NF_W'(1);
    end else begin
      unique case (state)
        IDLE: begin
          if (start) begin
            mode_r <= req.mode;
            key_r  <= req.logical_key;
            val_r  <= req.physical_value;
            req_r  <= req_lvl;
            page   <= root;
            if (req.mode == MODE_LOOKUP) begin
              lvl <= root_lvl;
              if (req_lvl > root_lvl) begin
                rsp   <= '{UNASSIGNED, 1'b0, 1'b0};
                state <= DONE;
              end else begin
                state <= WALK_RD;
              end
            end else if (req_lvl > root_lvl) begin
              lvl   <= req_lvl;
              state <= NEWCHK;
            end else begin
              lvl   <= root_lvl;
              state <= WALK_RD;
            end
          end
        end
        NEWCHK: begin
          if (lvl == root_lvl) begin
            page  <= root;
            state <= WALK_RD;
          end else if (slot != '0) begin
            extra <= lvl;
            state <= CHECK;
          end else begin
            lvl <= lvl - 1'b1;
          end
        end
        WALK_RD: begin
          state <= WALK_EV;
        end
        WALK_EV: begin
          if (lvl == '0) begin
            if (mode_r == MODE_LOOKUP) begin
              rsp   <= '{rdata, (rdata != UNASSIGNED), 1'b0};
              state <= DONE;
            end else begin
              extra <= '0;
              state <= CHECK;
            end
          end else if (!ptr_ok) begin
            if (mode_r == MODE_LOOKUP) begin
              rsp   <= '{UNASSIGNED, 1'b0, 1'b0};
              state <= DONE;
            end else begin
              extra <= lvl;
              state <= CHECK;
            end
          end else begin
            page  <= rdata[PAGE_W-1:0];
            lvl   <= lvl - 1'b1;
            state <= WALK_RD;
          end
        end
        CHECK: begin
          if (pool_need > SUM_W'(MAX_PAGES)) begin
            rsp   <= '{UNASSIGNED, 1'b0, 1'b1};
            state <= DONE;
          end else if (req_r > root_lvl) begin
            lvl   <= root_lvl + 1'b1;
            prev  <= root;
            state <= STACK;
          end else begin
            page  <= root;
            lvl   <= root_lvl;
            state <= EXEC_RD;
          end
        end
        STACK: begin
          fill_page  <= next_free[PAGE_W-1:0];
          fill_first <= VALUE_BITS'(prev);
          fill_cnt   <= '0;
          prev       <= next_free[PAGE_W-1:0];
          next_free  <= next_free + 1'b1;
          ret        <= STACK_NX;
          state      <= FILL;
        end
        STACK_NX: begin
          if (lvl == req_r) begin
            root     <= prev;
            root_lvl <= req_r;
            page     <= prev;
            state    <= EXEC_RD;
          end else begin
            lvl   <= lvl + 1'b1;
            state <= STACK;
          end
        end
        EXEC_RD: begin
          if (lvl == '0) begin
            rsp   <= '{val_r, 1'b1, 1'b0};
            state <= DONE;
          end else begin
            state <= EXEC_EV;
          end
        end
        EXEC_EV: begin
          lvl <= lvl - 1'b1;
          if (ptr_ok) begin
            page  <= rdata[PAGE_W-1:0];
            state <= EXEC_RD;
          end else begin
            page       <= next_free[PAGE_W-1:0];
            fill_page  <= next_free[PAGE_W-1:0];
            fill_first <= UNASSIGNED;
            fill_cnt   <= '0;
            next_free  <= next_free + 1'b1;
            ret        <= EXEC_RD;
            state      <= FILL;
          end
        end
        FILL: begin
          fill_cnt <= fill_cnt + 1'b1;
          if (fill_cnt == '1) begin
            state <= ret;
          end
        end
        DONE: begin
          if (take) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    next_free <= NF_W'(MAX_PAGES))
    else $error("page pool overrun");

  a_write_alloc: assert property (@(posedge clk) disable iff (rst)
    we |-> (NF_W'(addr[ADDR_W-1 -: PAGE_W]) < next_free))
    else $error("write to unallocated page");

  a_root_grows: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> root_lvl >= $past(root_lvl))
    else $error("root level shrank");

  a_root_moves: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && root_lvl != $past(root_lvl)) |-> root != $past(root))
    else $error("root level changed without new root page");

  a_lookup_ro: assert property (@(posedge clk) disable iff (rst)
    (mode_r == MODE_LOOKUP && (state == WALK_RD || state == WALK_EV)) |=>
      $stable(next_free))
    else $error("lookup allocated a page");

endmodule

`default_nettype wire

FILE: sv/radix_tree_address_map.sv
// Lookup: one RAM read per level from the root down; a missing page or a too-high key ends it early.
// Assign: a probe walk as for lookup (skipped if a key slot above the root is set), then
// a second walk that writes and fills each new page (root or missing) via the single RAM port.
// Throughput: one request at a time; the next is taken once the result sits in the output reg.
// Reset: synchronous; the root page is then cleared entry by entry while not ready.
`timescale 1ns / 1ps
`default_nettype none

module radix_tree_address_map
  import rtam_pkg::*;
#(
  parameter int CHUNK_LOG2 = DEF_CHUNK_LOG2,
  parameter int MAX_PAGES  = DEF_MAX_PAGES
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req_data,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp_data
);

  walk_stat_t stat;
  rsp_t       walk_rsp;
  logic       start, take;

  assign req_ready = stat.idle;
  assign start     = req_valid && req_ready;
  assign take      = stat.done && (!rsp_valid || rsp_ready);

  rtam_walker #(
    .CHUNK_LOG2 (CHUNK_LOG2),
    .MAX_PAGES  (MAX_PAGES)
  ) u_walker (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req_data),
    .take  (take),
    .stat  (stat),
    .rsp   (walk_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp_data <= walk_rsp;
    end
  end

endmodule

`default_nettype wire
